FILE: rtl/core/sctb_pkg.sv
// Shared types, codes, constants and microcode store of the SATA command table builder.
package sctb_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_PRD_ENTRIES_DEF   = 8;
   localparam int SECTORS_PER_ENTRY_DEF = 128;
   localparam int SLOT_COUNT_DEF        = 32;

   // A table never holds more entries than one request can report.
   localparam int ENTRY_LIMIT = 8;

   // Width used to compare sector counts against the entry size (up to 8192).
   localparam int SEC_CMP_W = 14;

   // Status codes of a result.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;

   // Request operations.
   localparam logic OP_READ_DMA_EXT = 1'b0;
   localparam logic OP_IDENTIFY     = 1'b1;

   // FIS and PRD constants.
   localparam logic [7:0]  CMD_READ_DMA_EXT = 8'h25;
   localparam logic [7:0]  CMD_IDENTIFY     = 8'hEC;
   localparam logic [7:0]  DEV_LBA_MODE     = 8'h40;
   localparam logic [15:0] IDENT_BCM1       = 16'h01FF;
   localparam logic [31:0] ENTRY_ADDR_STEP  = 32'h0001_0000;

   // Micro-operations that a control word can issue to the datapath.
   localparam logic [3:0] UOP_NOP         = 4'd0;
   localparam logic [3:0] UOP_LOAD        = 4'd1;
   localparam logic [3:0] UOP_PICK        = 4'd2;
   localparam logic [3:0] UOP_TINIT       = 4'd3;
   localparam logic [3:0] UOP_TCOUNT      = 4'd4;
   localparam logic [3:0] UOP_EINIT       = 4'd5;
   localparam logic [3:0] UOP_EMIT        = 4'd6;
   localparam logic [3:0] UOP_EMIT_NOSLOT = 4'd7;
   localparam logic [3:0] UOP_EMIT_IDENT  = 4'd8;
   localparam logic [3:0] UOP_EMIT_BAD    = 4'd9;

   // Jump conditions; when the condition is false the step counter advances.
   localparam logic [3:0] COND_NEVER    = 4'd0;
   localparam logic [3:0] COND_ALWAYS   = 4'd1;
   localparam logic [3:0] COND_NO_REQ   = 4'd2;
   localparam logic [3:0] COND_NO_FREE  = 4'd3;
   localparam logic [3:0] COND_IDENT    = 4'd4;
   localparam logic [3:0] COND_BAD_CNT  = 4'd5;
   localparam logic [3:0] COND_REM_GT   = 4'd6;
   localparam logic [3:0] COND_OUT_BUSY = 4'd7;
   localparam logic [3:0] COND_LEFT     = 4'd8;

   // Program addresses.
   localparam logic [3:0] PC_WAIT    = 4'd0;
   localparam logic [3:0] PC_PICK    = 4'd1;
   localparam logic [3:0] PC_TINIT   = 4'd2;
   localparam logic [3:0] PC_CHECK   = 4'd3;
   localparam logic [3:0] PC_TCOUNT  = 4'd4;
   localparam logic [3:0] PC_EINIT   = 4'd5;
   localparam logic [3:0] PC_EMIT    = 4'd6;
   localparam logic [3:0] PC_LOOP    = 4'd7;
   localparam logic [3:0] PC_DONE    = 4'd8;
   localparam logic [3:0] PC_NOSLOT  = 4'd9;
   localparam logic [3:0] PC_NOSLOT2 = 4'd10;
   localparam logic [3:0] PC_IDENT   = 4'd11;
   localparam logic [3:0] PC_IDENT2  = 4'd12;
   localparam logic [3:0] PC_BAD     = 4'd13;
   localparam logic [3:0] PC_BAD2    = 4'd14;

   typedef struct packed {
      logic [3:0] uop;
      logic [3:0] cond;
      logic [3:0] target;
   } ucode_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic [3:0] uop;
      logic       go;
   } ctl_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic no_free;
      logic is_ident;
      logic bad_count;
      logic rem_gt_per;
      logic out_free;
      logic entries_left;
   } flags_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  slot;
      logic [2:0]  entry_index;
      logic [3:0]  entry_total;
      logic [31:0] entry_addr;
      logic [15:0] byte_count_m1;
      logic [7:0]  ata_command;
      logic [7:0]  device_reg;
      logic [47:0] fis_lba;
      logic [15:0] fis_sector_count;
      logic        last;
   } rsp_type;

   // The control program.
   function automatic ucode_type ucode_rom(input logic [3:0] pc);
      ucode_type word;
      unique case (pc)
         PC_WAIT:    word = '{UOP_LOAD,        COND_NO_REQ,   PC_WAIT};
         PC_PICK:    word = '{UOP_PICK,        COND_NO_FREE,  PC_NOSLOT};
         PC_TINIT:   word = '{UOP_TINIT,       COND_IDENT,    PC_IDENT};
         PC_CHECK:   word = '{UOP_NOP,         COND_BAD_CNT,  PC_BAD};
         PC_TCOUNT:  word = '{UOP_TCOUNT,      COND_REM_GT,   PC_TCOUNT};
         PC_EINIT:   word = '{UOP_EINIT,       COND_NEVER,    PC_WAIT};
         PC_EMIT:    word = '{UOP_EMIT,        COND_OUT_BUSY, PC_EMIT};
         PC_LOOP:    word = '{UOP_NOP,         COND_LEFT,     PC_EMIT};
         PC_DONE:    word = '{UOP_NOP,         COND_ALWAYS,   PC_WAIT};
         PC_NOSLOT:  word = '{UOP_EMIT_NOSLOT, COND_OUT_BUSY, PC_NOSLOT};
         PC_NOSLOT2: word = '{UOP_NOP,         COND_ALWAYS,   PC_WAIT};
         PC_IDENT:   word = '{UOP_EMIT_IDENT,  COND_OUT_BUSY, PC_IDENT};
         PC_IDENT2:  word = '{UOP_NOP,         COND_ALWAYS,   PC_WAIT};
         PC_BAD:     word = '{UOP_EMIT_BAD,    COND_OUT_BUSY, PC_BAD};
         PC_BAD2:    word = '{UOP_NOP,         COND_ALWAYS,   PC_WAIT};
         default:    word = '{UOP_NOP,         COND_ALWAYS,   PC_WAIT};
      endcase
      return word;
   endfunction

endpackage

FILE: rtl/core/sctb_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module sctb_seq import sctb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   input  flags_type flags,
   output logic      req_tready,
   output ctl_type   ctl
);

   logic [3:0] pc_ff;
   logic [3:0] pc_in;
   ucode_type  word;
   logic       req_accept;
   logic       jump;

   assign word       = ucode_rom(pc_ff);
   assign req_tready = (word.uop == UOP_LOAD);
   assign req_accept = req_tvalid && req_tready;

   // Evaluate the jump condition of the current control word.
   always_comb begin
      unique case (word.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_accept;
         COND_NO_FREE:  jump = flags.no_free;
         COND_IDENT:    jump = flags.is_ident;
         COND_BAD_CNT:  jump = flags.bad_count;
         COND_REM_GT:   jump = flags.rem_gt_per;
         COND_OUT_BUSY: jump = !flags.out_free;
         COND_LEFT:     jump = flags.entries_left;
         default:       jump = 1'b1;
      endcase
   end

   // The go bit tells the datapath whether the current step takes effect.
   always_comb begin
      ctl.uop = word.uop;
      unique case (word.uop)
         UOP_LOAD:        ctl.go = req_accept;
         UOP_TCOUNT:      ctl.go = flags.rem_gt_per;
         UOP_EMIT:        ctl.go = flags.out_free;
         UOP_EMIT_NOSLOT: ctl.go = flags.out_free;
         UOP_EMIT_IDENT:  ctl.go = flags.out_free;
         UOP_EMIT_BAD:    ctl.go = flags.out_free;
         default:         ctl.go = 1'b1;
      endcase
   end

   assign pc_in = jump ? word.target : pc_ff + 4'd1;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/core/sctb_dp.sv
// Datapath: request registers, slot search, entry counters and the result register.
module sctb_dp import sctb_pkg::*; #(
   parameter int MAX_PRD_ENTRIES   = MAX_PRD_ENTRIES_DEF,
   parameter int SECTORS_PER_ENTRY = SECTORS_PER_ENTRY_DEF,
   parameter int SLOT_COUNT        = SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  logic        req_op,
   input  logic [31:0] req_busy_slots,
   input  logic [47:0] req_start_lba,
   input  logic [31:0] req_data_addr,
   input  logic [10:0] req_sector_count,
   input  logic        rsp_tready,
   output logic        rsp_valid,
   output rsp_type     rsp,
   output flags_type   flags
);

   localparam int CAP_ENTRIES = (MAX_PRD_ENTRIES < ENTRY_LIMIT) ? MAX_PRD_ENTRIES : ENTRY_LIMIT;
   localparam int CAP_SECTORS = CAP_ENTRIES * SECTORS_PER_ENTRY;
   localparam logic [16:0] CAP_SEC = 17'(CAP_SECTORS);
   localparam logic [SEC_CMP_W-1:0] PER = SEC_CMP_W'(SECTORS_PER_ENTRY);

   // Captured request.
   logic        op_ff;
   logic [31:0] busy_ff;
   logic [47:0] lba_ff;
   logic [31:0] base_ff;
   logic [10:0] count_ff;

   // Working registers.
   logic [4:0]  slot_ff;
   logic [10:0] remain_ff, remain_in;
   logic [3:0]  total_ff, total_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] addr_ff, addr_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [4:0]            pick_slot;
   logic                  pick_found;
   logic [SEC_CMP_W-1:0]  remain_w;
   logic [SEC_CMP_W-1:0]  remain_sub;
   logic [SEC_CMP_W-1:0]  secs;
   logic [SEC_CMP_W+8:0]  bytes_m1;
   logic                  is_last;
   logic                  out_free;

   // Lowest clear bit among the usable slots.
   always_comb begin
      pick_slot  = '0;
      pick_found = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            pick_slot  = 5'(i);
            pick_found = 1'b1;
         end
      end
   end

   assign remain_w   = SEC_CMP_W'(remain_ff);
   assign remain_sub = remain_w - PER;
   assign is_last    = ((idx_ff + 4'd1) == total_ff);
   assign secs       = is_last ? remain_w : PER;
   assign bytes_m1   = {secs, 9'd0} - (SEC_CMP_W+9)'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Status toward the sequencer.
   always_comb begin
      flags.no_free      = !pick_found;
      flags.is_ident     = (op_ff == OP_IDENTIFY);
      flags.bad_count    = (count_ff == 11'd0) || ({6'd0, count_ff} > CAP_SEC);
      flags.rem_gt_per   = (remain_w > PER);
      flags.out_free     = out_free;
      flags.entries_left = (idx_ff < total_ff);
   end

   // Counter updates for the total pass and the emit pass.
   always_comb begin
      remain_in = remain_ff;
      total_in  = total_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      case (ctl.uop)
         UOP_TINIT: begin
            remain_in = count_ff;
            total_in  = 4'd1;
         end
         UOP_TCOUNT: begin
            if (ctl.go) begin
               remain_in = remain_sub[10:0];
               total_in  = total_ff + 4'd1;
            end
         end
         UOP_EINIT: begin
            remain_in = count_ff;
            idx_in    = '0;
            addr_in   = base_ff;
         end
         UOP_EMIT: begin
            if (ctl.go) begin
               remain_in = remain_sub[10:0];
               idx_in    = idx_ff + 4'd1;
               addr_in   = addr_ff + ENTRY_ADDR_STEP;
            end
         end
         default: begin
         end
      endcase
   end

   // Build the next result.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctl.go) begin
         case (ctl.uop)
            UOP_EMIT: begin
               rsp_in                  = '0;
               rsp_in.status           = STATUS_OK;
               rsp_in.slot             = slot_ff;
               rsp_in.entry_index      = idx_ff[2:0];
               rsp_in.entry_total      = total_ff;
               rsp_in.entry_addr       = addr_ff;
               rsp_in.byte_count_m1    = bytes_m1[15:0];
               rsp_in.ata_command      = CMD_READ_DMA_EXT;
               rsp_in.device_reg       = DEV_LBA_MODE;
               rsp_in.fis_lba          = lba_ff;
               rsp_in.fis_sector_count = {5'd0, count_ff};
               rsp_in.last             = is_last;
               rsp_valid_in            = 1'b1;
            end
            UOP_EMIT_NOSLOT: begin
               rsp_in        = '0;
               rsp_in.status = STATUS_NO_SLOT;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
            end
            UOP_EMIT_IDENT: begin
               rsp_in               = '0;
               rsp_in.status        = STATUS_OK;
               rsp_in.slot          = slot_ff;
               rsp_in.entry_total   = 4'd1;
               rsp_in.entry_addr    = base_ff;
               rsp_in.byte_count_m1 = IDENT_BCM1;
               rsp_in.ata_command   = CMD_IDENTIFY;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
            end
            UOP_EMIT_BAD: begin
               rsp_in        = '0;
               rsp_in.status = STATUS_BAD_COUNT;
               rsp_in.slot   = slot_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.go && (ctl.uop == UOP_LOAD)) begin
         op_ff    <= req_op;
         busy_ff  <= req_busy_slots;
         lba_ff   <= req_start_lba;
         base_ff  <= req_data_addr;
         count_ff <= req_sector_count;
      end
      if (ctl.uop == UOP_PICK) begin
         slot_ff <= pick_slot;
      end
      remain_ff <= remain_in;
      total_ff  <= total_in;
      idx_ff    <= idx_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/sata_command_table_builder.sv
// Top level of the SATA command table builder: stream ports, sequencer and datapath.
//
//   Channel   Direction  Carries
//   req_*     in         one command request (op in tuser, fields in tdata)
//   rsp_*     out        one PRD entry result (status in tuser, fields in tdata)
//
// A read of n entries runs four steps up to the count check, n steps in the counting
// loop, one setup step, two steps per entry in the emit loop and one closing step.
// An identify request, a bad count and a busy mask end in their own emit and closing steps.
// Reset is synchronous and returns the step counter to its wait step and empties
// the result register.
// An emit step holds while the result register is full and not being taken;
// the next request is accepted while the last result still waits.
module sata_command_table_builder import sctb_pkg::*; #(
   parameter int MAX_PRD_ENTRIES   = MAX_PRD_ENTRIES_DEF,
   parameter int SECTORS_PER_ENTRY = SECTORS_PER_ENTRY_DEF,
   parameter int SLOT_COUNT        = SLOT_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // busy_slots, start_lba, data_addr, sector_count, zero pad
   input  logic         req_tuser,  // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,  // slot, entry_index, entry_total, entry_addr,
                                    // byte_count_m1, ata_command, device_reg, fis_lba,
                                    // fis_sector_count, zero pad
   output logic [1:0]   rsp_tuser,  // status
   output logic         rsp_tlast
);

   ctl_type   ctl;
   flags_type flags;
   rsp_type   rsp;

   sctb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .flags      (flags),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   sctb_dp #(
      .MAX_PRD_ENTRIES   (MAX_PRD_ENTRIES),
      .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
      .SLOT_COUNT        (SLOT_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_op           (req_tuser),
      .req_busy_slots   (req_tdata[31:0]),
      .req_start_lba    (req_tdata[79:32]),
      .req_data_addr    (req_tdata[111:80]),
      .req_sector_count (req_tdata[122:112]),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp              (rsp),
      .flags            (flags)
   );

   // Pack the result register onto the stream.
   assign rsp_tdata = {4'd0, rsp.fis_sector_count, rsp.fis_lba, rsp.device_reg,
                       rsp.ata_command, rsp.byte_count_m1, rsp.entry_addr,
                       rsp.entry_total, rsp.entry_index, rsp.slot};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
